// ===== rtl/ohpp_pkg.sv =====
package ohpp_pkg;

    // Bin index width, wide enough for the largest supported bin count.
    localparam int BIN_IDX_W = 6;

    // Tolerance register.
    localparam int         TOL_W     = 4;
    localparam logic [3:0] TOL_RESET = 4'd10;

    // Stream field widths.
    localparam int ANGLE_W  = 8;
    localparam int OUT_BIN_W = 5;
    localparam int OUT_CNT_W = 16;
    localparam int OUT_DATA_W = 48;

    // Angles at or above this wrap back by the same amount.
    localparam logic [7:0] ANGLE_WRAP = 8'd180;

    // Offset that keeps (angle - tolerance) positive for the bin table.
    localparam logic [8:0] LUT_OFFSET = 9'd16;

    // Mode codes carried in tuser.
    localparam logic MODE_ADD    = 1'b0;
    localparam logic MODE_REPORT = 1'b1;

    // Control broadcast from the sequencer to every cell of the chain.
    typedef struct packed {
        logic                 add;
        logic                 shift;
        logic [BIN_IDX_W-1:0] own;
        logic [BIN_IDX_W-1:0] up;
        logic [BIN_IDX_W-1:0] dn;
    } t_cell_ctl;

endpackage

// ===== rtl/ohpp_cell.sv =====
module ohpp_cell #(
    parameter int COUNT_WIDTH = 16,
    parameter int INDEX       = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ohpp_pkg::t_cell_ctl   i_ctl,
    input  logic [COUNT_WIDTH-1:0] i_next,
    output logic [COUNT_WIDTH-1:0] o_count
);

    localparam logic [ohpp_pkg::BIN_IDX_W-1:0] MY_BIN = ohpp_pkg::BIN_IDX_W'(INDEX);
    localparam logic [COUNT_WIDTH:0] CNT_MAX = {1'b0, {COUNT_WIDTH{1'b1}}};

    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] n_count;
    logic                   hit_own;
    logic                   hit_up;
    logic                   hit_dn;
    logic [1:0]             inc;
    logic [COUNT_WIDTH:0]   sum;

    // Neighbor bins count only where they differ from the own bin; up and dn
    // may land on the same bin, which then gets two.
    always_comb begin
        hit_own = (i_ctl.own == MY_BIN);
        hit_up  = (i_ctl.up == MY_BIN) && (i_ctl.up != i_ctl.own);
        hit_dn  = (i_ctl.dn == MY_BIN) && (i_ctl.dn != i_ctl.own);
        inc     = 2'(hit_own) + 2'(hit_up) + 2'(hit_dn);
        sum     = {1'b0, r_count} + (COUNT_WIDTH+1)'(inc);
        n_count = (sum > CNT_MAX) ? CNT_MAX[COUNT_WIDTH-1:0] : sum[COUNT_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.shift) begin
            r_count <= i_next;
        end else if (i_ctl.add) begin
            r_count <= n_count;
        end
    end

    assign o_count = r_count;

endmodule

// ===== rtl/orientation_histogram_peak_pair.sv =====
// Channel   Dir  Ports                          Content
// --------  ---  -----------------------------  ---------------------------------------------
// s stream  in   i_s_tvalid/o_s_tready          tdata: angle_deg; tuser: mode
// m stream  out  o_m_tvalid/i_m_tready          tdata: primary/secondary bin and count
// config    in   i_cfg_wen/i_cfg_wdata          angle_tolerance, 4 bits
//
// Add words are taken one per cycle while o_s_tready is high; each updates the cell chain
// in the next cycle. A report word runs to its result in three steps: ST_SCAN rotates the
// chain past the peak scanner, ST_CLEAR shifts zeros in while the three bins around the
// perpendicular are captured, and ST_PICK picks the secondary.
// No input is taken during a report, nor while an unread result waits with i_m_tready low.
// Reset is synchronous and clears every count and sets the tolerance to 10.
module orientation_histogram_peak_pair #(
    parameter int DEG_PER_BIN = 10,
    parameter int NUM_BINS    = 18,
    parameter int COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config
    input  logic        i_cfg_wen,
    input  logic [3:0]  i_cfg_wdata,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] angle_deg
    input  logic        i_s_tuser,   // [0] mode
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata    // [4:0] primary_bin, [20:5] primary_count,
                                     // [25:21] secondary_bin, [41:26] secondary_count,
                                     // [47:42] zero
);

    localparam int IW   = ohpp_pkg::BIN_IDX_W;
    localparam int KW   = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int HALF = NUM_BINS / 2;
    localparam logic [KW-1:0] LAST_BIN = KW'(NUM_BINS - 1);

    typedef logic [IW-1:0] t_lut [256];

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_CLEAR = 4'b0100,
        ST_PICK  = 4'b1000
    } t_state;

    // Bin of (v - 16), wrapped modulo NUM_BINS, built by stepping through the
    // degrees so that floor division needs no divider.
    function automatic t_lut build_lut();
        t_lut lut;
        int   q_w;
        int   r;
        int   v;
        lut = '{default: '0};
        q_w = NUM_BINS - 4;
        r   = 0;
        for (v = -4 * DEG_PER_BIN; v <= 239; v++) begin
            if (v >= -16) begin
                lut[v + 16] = IW'(q_w);
            end
            r++;
            if (r == DEG_PER_BIN) begin
                r   = 0;
                q_w = (q_w == NUM_BINS - 1) ? 0 : q_w + 1;
            end
        end
        return lut;
    endfunction

    localparam t_lut BIN_LUT = build_lut();

    // Clamp a count to the 16-bit result field.
    function automatic logic [15:0] sat16(input logic [COUNT_WIDTH-1:0] c);
        logic [COUNT_WIDTH+15:0] ext;
        ext = (COUNT_WIDTH+16)'(c);
        return (ext > (COUNT_WIDTH+16)'(16'hFFFF)) ? 16'hFFFF : ext[15:0];
    endfunction

    t_state                 r_state;
    t_state                 n_state;
    logic [3:0]             r_tol;
    logic                   r_add;
    logic [IW-1:0]          r_own;
    logic [IW-1:0]          r_up;
    logic [IW-1:0]          r_dn;
    logic [KW-1:0]          r_k;
    logic [KW-1:0]          r_p;
    logic [COUNT_WIDTH-1:0] r_best;
    logic [COUNT_WIDTH-1:0] r_c [3];
    logic                   r_out_vld;
    logic [47:0]            r_out_data;

    logic                   s_acc;
    logic [7:0]             ang;
    logic [8:0]             idx_own;
    logic [8:0]             idx_up;
    logic [8:0]             idx_dn;
    logic [KW:0]            sec_sum [3];
    logic [KW-1:0]          sec_idx [3];
    logic [KW-1:0]          s_bin;
    logic [COUNT_WIDTH-1:0] s_cnt;
    logic [COUNT_WIDTH-1:0] head;
    logic [COUNT_WIDTH-1:0] feedback;
    logic [COUNT_WIDTH-1:0] counts [NUM_BINS];
    ohpp_pkg::t_cell_ctl    cell_ctl;

    // Take an input word only in idle and when the result register is free or being freed.
    assign o_s_tready = (r_state == ST_IDLE) && (!r_out_vld || i_m_tready);
    assign s_acc      = i_s_tvalid && o_s_tready;

    // Fold angles at or above 180 back, then look up own and neighbor bins.
    always_comb begin
        ang     = (i_s_tdata >= ohpp_pkg::ANGLE_WRAP) ? (i_s_tdata - ohpp_pkg::ANGLE_WRAP)
                                                     : i_s_tdata;
        idx_own = {1'b0, ang} + ohpp_pkg::LUT_OFFSET;
        idx_up  = idx_own + 9'(r_tol);
        idx_dn  = idx_own - 9'(r_tol);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= ohpp_pkg::TOL_RESET;
        end else if (i_cfg_wen) begin
            r_tol <= i_cfg_wdata;
        end
    end

    // Register the decoded bins; the cells add them in the next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_add <= 1'b0;
        end else begin
            r_add <= s_acc && (i_s_tuser == ohpp_pkg::MODE_ADD);
        end
        r_own <= BIN_LUT[idx_own[7:0]];
        r_up  <= BIN_LUT[idx_up[7:0]];
        r_dn  <= BIN_LUT[idx_dn[7:0]];
    end

    always_comb begin
        cell_ctl.add   = r_add;
        cell_ctl.shift = (r_state == ST_SCAN) || (r_state == ST_CLEAR);
        cell_ctl.own   = r_own;
        cell_ctl.up    = r_up;
        cell_ctl.dn    = r_dn;
    end

    // Rotate during the peak scan, shift zeros in during the clearing pass.
    assign head     = counts[0];
    assign feedback = (r_state == ST_SCAN) ? head : '0;

    for (genvar g = 0; g < NUM_BINS; g++) begin : g_cell
        ohpp_cell #(
            .COUNT_WIDTH (COUNT_WIDTH),
            .INDEX       (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (cell_ctl),
            .i_next  ((g == NUM_BINS - 1) ? feedback : counts[(g + 1) % NUM_BINS]),
            .o_count (counts[g])
        );
    end

    // The three bins around the primary's perpendicular; each sum stays below
    // twice the bin count, so one subtract wraps it.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            sec_sum[j] = (KW+1)'(r_p) + (KW+1)'(HALF - 1 + j);
            sec_idx[j] = (sec_sum[j] >= (KW+1)'(NUM_BINS))
                       ? KW'(sec_sum[j] - (KW+1)'(NUM_BINS)) : sec_sum[j][KW-1:0];
        end
    end

    // Earliest wins on ties.
    always_comb begin
        s_bin = sec_idx[0];
        s_cnt = r_c[0];
        if (r_c[1] > s_cnt) begin
            s_bin = sec_idx[1];
            s_cnt = r_c[1];
        end
        if (r_c[2] > s_cnt) begin
            s_bin = sec_idx[2];
            s_cnt = r_c[2];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_acc && (i_s_tuser == ohpp_pkg::MODE_REPORT)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_k == LAST_BIN) begin
                    n_state = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                if (r_k == LAST_BIN) begin
                    n_state = ST_PICK;
                end
            end
            ST_PICK: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_SCAN) || (r_state == ST_CLEAR)) begin
                r_k <= (r_k == LAST_BIN) ? '0 : r_k + 1'b1;
            end else begin
                r_k <= '0;
            end
        end
    end

    // Peak scan: the head of the chain holds bin r_k; strict compare keeps the
    // first bin with the largest count.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SCAN) begin
            if ((r_k == '0) || (head > r_best)) begin
                r_best <= head;
                r_p    <= r_k;
            end
        end
        if (r_state == ST_CLEAR) begin
            for (int j = 0; j < 3; j++) begin
                if (r_k == sec_idx[j]) begin
                    r_c[j] <= head;
                end
            end
        end
    end

    // Result register: hold until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_state == ST_PICK) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
        if (r_state == ST_PICK) begin
            r_out_data <= {6'b0, sat16(s_cnt), 5'(s_bin), sat16(r_best), 5'(r_p)};
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

    a_out_from_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state == ST_PICK))
        else $error("result raised without a pick cycle");

    a_report_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && (i_s_tuser == ohpp_pkg::MODE_REPORT)) |=> (r_state == ST_SCAN && r_k == '0))
        else $error("report word did not start the scan at bin zero");

    a_cleared_at_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PICK) |-> (counts[0] == '0 && counts[NUM_BINS-1] == '0))
        else $error("histogram not cleared after report");

    a_no_add_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && $past(r_state == ST_SCAN)) |-> !r_add)
        else $error("add pending while chain is shifting");

endmodule

// ===== dv/tb.sv =====
module tb;

    localparam int BIN_DEG      = 10;
    localparam int HIST_BINS    = 18;
    localparam int TALLY_W      = 16;
    localparam int HALF_BINS    = HIST_BINS / 2;
    // Wait long enough for a report to run through scan, clear and pick, with margin on top.
    localparam int DRAIN_CYCLES = 2 * HIST_BINS + 8;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int MAX_SHOWN    = 10;

    // Result word as it sits on o_m_tdata, lowest field last.
    typedef struct packed {
        logic [5:0]  pad;
        logic [15:0] scnt;
        logic [4:0]  sbin;
        logic [15:0] pcnt;
        logic [4:0]  pbin;
    } t_peak_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wen;
    logic [3:0]  i_cfg_wdata;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;   // [7:0] angle_deg
    logic        i_s_tuser;   // [0] mode
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [47:0] o_m_tdata;   // [4:0] primary_bin, [20:5] primary_count,
                              // [25:21] secondary_bin, [41:26] secondary_count

    // Predicted histogram and tolerance, mirrored from what the block was sent.
    logic [TALLY_W-1:0] bin_tally [HIST_BINS];
    logic [3:0]         tol_now;

    // Peak reports still owed by the block, oldest first.
    t_peak_word peak_reports_due [$];

    int unsigned mismatch_count;
    int unsigned cycle_count;
    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;

    orientation_histogram_peak_pair #(
        .DEG_PER_BIN (BIN_DEG),
        .NUM_BINS    (HIST_BINS),
        .COUNT_WIDTH (TALLY_W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always #1 i_clk = ~i_clk;

    // Bound the run; a hang shows up as a failure here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Stall the result side at random; a zero percentage keeps ready high.
    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Floor-divide an angle into its bin, then wrap modulo the bin count.
    function automatic int bin_of(input int deg);
        int q;
        q = (deg >= 0) ? deg / BIN_DEG : -((-deg + BIN_DEG - 1) / BIN_DEG);
        q = q % HIST_BINS;
        if (q < 0)
            q += HIST_BINS;
        return q;
    endfunction

    // Add one to a bin, holding at full scale.
    function automatic void bump_bin(input int b);
        if (bin_tally[b] != '1)
            bin_tally[b] = bin_tally[b] + 1'b1;
    endfunction

    // Count one angle in its own bin and in the two tolerance neighbors.
    function automatic void tally_angle(input logic [7:0] angle);
        int a;
        int own;
        int up;
        int dn;
        a   = int'(angle) % 180;
        own = bin_of(a);
        up  = bin_of(a + int'(tol_now));
        dn  = bin_of(a - int'(tol_now));
        bump_bin(own);
        if (up != own)
            bump_bin(up);
        if (dn != own)
            bump_bin(dn);
    endfunction

    // Find the first peak and the best bin near its perpendicular, queue the
    // word the block must return, then empty the histogram.
    function automatic void predict_peaks();
        t_peak_word         w;
        int                 p;
        int                 s;
        int                 idx;
        int                 i;
        logic [TALLY_W-1:0] pc;
        logic [TALLY_W-1:0] sc;
        p  = 0;
        pc = bin_tally[0];
        for (i = 1; i < HIST_BINS; i++) begin
            if (bin_tally[i] > pc) begin
                pc = bin_tally[i];
                p  = i;
            end
        end
        s  = (p + HALF_BINS + HIST_BINS - 1) % HIST_BINS;
        sc = bin_tally[s];
        for (i = 1; i < 3; i++) begin
            idx = (p + HALF_BINS + HIST_BINS - 1 + i) % HIST_BINS;
            if (bin_tally[idx] > sc) begin
                sc = bin_tally[idx];
                s  = idx;
            end
        end
        w      = '0;
        w.pbin = 5'(p);
        w.pcnt = pc;
        w.sbin = 5'(s);
        w.scnt = sc;
        peak_reports_due.insert(peak_reports_due.size(), w);
        for (i = 0; i < HIST_BINS; i++)
            bin_tally[i] = '0;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            mismatch_count++;
            if (mismatch_count <= MAX_SHOWN)
                $display("t=%0t %s: expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // Score every result word against the oldest prediction.
    always @(posedge i_clk) begin
        t_peak_word got;
        t_peak_word want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata;
            if (peak_reports_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_SHOWN)
                    $display("t=%0t unexpected result word %h", $time, o_m_tdata);
            end else begin
                want = peak_reports_due.pop_front();
                check_field("primary_bin", want.pbin, got.pbin);
                check_field("primary_count", want.pcnt, got.pcnt);
                check_field("secondary_bin", want.sbin, got.sbin);
                check_field("secondary_count", want.scnt, got.scnt);
                check_field("padding", want.pad, got.pad);
            end
        end
    end

    // Send one word, with random idle cycles ahead of it; predict on acceptance.
    task automatic push_word(input logic mode, input logic [7:0] angle);
        @(negedge i_clk);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            i_s_tvalid = 1'b0;
            i_s_tdata  = 8'($urandom);
            i_s_tuser  = 1'($urandom);
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = angle;
        i_s_tuser  = mode;
        do
            @(posedge i_clk);
        while (!o_s_tready);
        if (mode == ohpp_pkg::MODE_REPORT)
            predict_peaks();
        else
            tally_angle(angle);
    endtask

    // Drop valid and wait until every owed report is in, then let the chain settle.
    task automatic hold_until_drained();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (peak_reports_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_tolerance(input logic [3:0] t);
        hold_until_drained();
        @(negedge i_clk);
        i_cfg_wen   = 1'b1;
        i_cfg_wdata = t;
        @(posedge i_clk);
        tol_now = t;
        @(negedge i_clk);
        i_cfg_wen   = 1'b0;
        i_cfg_wdata = 4'($urandom);
    endtask

    // Pick an angle: mostly clustered around a focus or its perpendicular so
    // that peaks and near-ties form, the rest spread, on bin edges or wrapped.
    function automatic logic [7:0] pick_angle(input int focus);
        int a;
        case ($urandom_range(9))
            0, 1:    a = $urandom_range(255);
            2:       a = $urandom_range(17) * BIN_DEG + ($urandom_range(1) ? 0 : BIN_DEG - 1);
            3:       a = $urandom_range(255, 170);
            4, 5:    a = (focus + 90 + $urandom_range(12) - 6 + 180) % 180;
            default: a = (focus + $urandom_range(8) - 4 + 180) % 180;
        endcase
        return 8'(a);
    endfunction

    // Empty histogram, angle wrap, bin edges, both tolerance extremes, and ties.
    task automatic test_directed_corners();
        push_word(ohpp_pkg::MODE_REPORT, 8'd0);
        push_word(ohpp_pkg::MODE_ADD, 8'd0);
        push_word(ohpp_pkg::MODE_ADD, 8'd180);
        push_word(ohpp_pkg::MODE_ADD, 8'd255);
        push_word(ohpp_pkg::MODE_ADD, 8'd179);
        push_word(ohpp_pkg::MODE_ADD, 8'd9);
        push_word(ohpp_pkg::MODE_ADD, 8'd10);
        push_word(ohpp_pkg::MODE_REPORT, 8'd255);
        write_tolerance(4'd0);
        push_word(ohpp_pkg::MODE_ADD, 8'd5);
        push_word(ohpp_pkg::MODE_ADD, 8'd5);
        push_word(ohpp_pkg::MODE_ADD, 8'd175);
        push_word(ohpp_pkg::MODE_ADD, 8'd95);
        push_word(ohpp_pkg::MODE_ADD, 8'd85);
        push_word(ohpp_pkg::MODE_REPORT, 8'd90);
        write_tolerance(4'd15);
        push_word(ohpp_pkg::MODE_ADD, 8'd0);
        push_word(ohpp_pkg::MODE_ADD, 8'd128);
        push_word(ohpp_pkg::MODE_REPORT, 8'd170);
        write_tolerance(4'd0);
        push_word(ohpp_pkg::MODE_ADD, 8'd30);
        push_word(ohpp_pkg::MODE_ADD, 8'd150);
        push_word(ohpp_pkg::MODE_REPORT, 8'd1);
    endtask

    // Walk every register value with a short burst of angles for each.
    task automatic test_tolerance_sweep();
        int t;
        int n;
        int focus;
        for (t = 0; t < 16; t++) begin
            write_tolerance(4'(t));
            focus = $urandom_range(179);
            for (n = 0; n < 8; n++)
                push_word(ohpp_pkg::MODE_ADD, pick_angle(focus));
            push_word(ohpp_pkg::MODE_REPORT, 8'($urandom));
        end
    endtask

    // Mixed traffic: mostly adds, a report now and then, occasional full drains.
    task automatic test_random_traffic(input int unsigned src_pct, input int unsigned snk_pct,
                                       input int n_items);
        int i;
        int focus;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        focus        = $urandom_range(179);
        for (i = 0; i < n_items; i++) begin
            if (i % 120 == 0)
                write_tolerance(4'($urandom_range(15)));
            else if ($urandom_range(59) == 0)
                hold_until_drained();
            if ($urandom_range(13) == 0) begin
                push_word(ohpp_pkg::MODE_REPORT, 8'($urandom));
                focus = $urandom_range(179);
                // back-to-back reports see an empty histogram
                if ($urandom_range(7) == 0)
                    push_word(ohpp_pkg::MODE_REPORT, 8'($urandom));
            end else begin
                push_word(ohpp_pkg::MODE_ADD, pick_angle(focus));
            end
        end
    endtask

    initial begin
        int i;
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_wen      = 1'b0;
        i_cfg_wdata    = '0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_s_tuser      = ohpp_pkg::MODE_ADD;
        i_m_tready     = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        src_idle_pct   = 32;
        snk_idle_pct   = 54;
        tol_now        = ohpp_pkg::TOL_RESET;
        for (i = 0; i < HIST_BINS; i++)
            bin_tally[i] = '0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_corners();
        test_tolerance_sweep();
        test_random_traffic(32, 54, 370);
        test_random_traffic(54, 32, 370);
        test_random_traffic(0, 0, 370);

        hold_until_drained();
        if (mismatch_count == 0 && peak_reports_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
